>>> hdl/nsvp_pkg.sv
package nsvp_pkg;

  localparam int IDX_W       = 4;
  localparam int COORD_W     = 12;
  localparam int COLOR_W     = 8;
  localparam int COUNT_W     = 5;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // One queued operation; a query carries its pixel in x and y.
  typedef struct packed {
    cmd_t               cmd;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } op_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [IDX_W-1:0]   idx;
    logic               no_seed;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    back_state_t state;
    logic        result_valid;
  } back_status_t;

endpackage

>>> hdl/nearest_seed_voronoi_pixel_top.sv
// Nearest-seed Voronoi pixel colorer. A load item (command 0) writes one
// entry of the seed table; a query item (command 1) returns the color and
// index of the seed nearest to the pixel by squared Euclidean distance,
// scanning entries 0 to seed_count-1 (saturated at MAX_SEEDS), lowest
// index winning ties. With no seeds in use the result has zero color and
// index and no_seed set. Loads give no result. Items pass through a
// two-entry command queue, so the input keeps taking items, until it is
// full, while a result waits to be popped. In the back end a query reads
// one table entry per cycle on the single read port of the seed RAM, into
// a three-stage distance pipeline and a result hand-off. Items are carried
// out one at a time, in order. The seed table has no reset; every entry
// below seed_count must be loaded before a query reads it. The user must
// write seed_count only while idle; the block itself does not enforce it.
module nearest_seed_voronoi_pixel_top #(
  parameter int MAX_SEEDS  = 16,
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  // config
  input  logic                          seed_count_we,
  input  logic [nsvp_pkg::COUNT_W-1:0]  seed_count,
  // item input
  input  logic                          push,
  output logic                          full,
  input  logic                          command,
  input  logic [nsvp_pkg::IDX_W-1:0]    seed_index,
  input  logic [nsvp_pkg::COORD_W-1:0]  seed_x,
  input  logic [nsvp_pkg::COORD_W-1:0]  seed_y,
  input  logic [nsvp_pkg::COLOR_W-1:0]  seed_red,
  input  logic [nsvp_pkg::COLOR_W-1:0]  seed_green,
  input  logic [nsvp_pkg::COLOR_W-1:0]  seed_blue,
  input  logic [nsvp_pkg::COORD_W-1:0]  pixel_x,
  input  logic [nsvp_pkg::COORD_W-1:0]  pixel_y,
  // result output
  output logic                          empty,
  input  logic                          pop,
  output logic [nsvp_pkg::COLOR_W-1:0]  out_red,
  output logic [nsvp_pkg::COLOR_W-1:0]  out_green,
  output logic [nsvp_pkg::COLOR_W-1:0]  out_blue,
  output logic [nsvp_pkg::IDX_W-1:0]    nearest_index,
  output logic                          no_seed
);

  logic [nsvp_pkg::COUNT_W-1:0] active_count;
  logic                         op_valid;
  logic                         op_ready;
  nsvp_pkg::op_t                op;
  nsvp_pkg::result_t            res;
  nsvp_pkg::back_status_t       bstat;
  logic                         res_pop;

  // seed_count register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= '0;
    end else if (seed_count_we) begin
      active_count <= seed_count;
    end
  end

  // Front: accept, classify, queue
  nsvp_front #(
    .MAX_SEEDS(MAX_SEEDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .seed_index(seed_index),
    .seed_x    (seed_x),
    .seed_y    (seed_y),
    .seed_red  (seed_red),
    .seed_green(seed_green),
    .seed_blue (seed_blue),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op)
  );

  // Back: table writes and nearest-seed scan
  nsvp_back #(
    .MAX_SEEDS (MAX_SEEDS),
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .seed_count(active_count),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_pop   (res_pop),
    .res       (res),
    .status    (bstat)
  );

  assign empty         = !bstat.result_valid;
  assign res_pop       = pop && !empty;
  assign out_red       = res.red;
  assign out_green     = res.green;
  assign out_blue      = res.blue;
  assign nearest_index = res.idx;
  assign no_seed       = res.no_seed;

`ifndef ASSERT_OFF
  // A no_seed result carries zero color and index.
  a_no_seed_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && no_seed) |->
      (out_red == '0 && out_green == '0 && out_blue == '0 && nearest_index == '0))
    else $error("no_seed result with nonzero payload");

  // A result shows up only as the back end leaves its done state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(bstat.state == nsvp_pkg::ST_DONE))
    else $error("result appeared without a finished query");

  // Both queues come out of reset drained.
  a_reset_drained: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not drained after reset");
`endif

endmodule

>>> hdl/nsvp_ram.sv
module nsvp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/nsvp_front.sv
module nsvp_front #(
  parameter int MAX_SEEDS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            command,
  input  logic [nsvp_pkg::IDX_W-1:0]      seed_index,
  input  logic [nsvp_pkg::COORD_W-1:0]    seed_x,
  input  logic [nsvp_pkg::COORD_W-1:0]    seed_y,
  input  logic [nsvp_pkg::COLOR_W-1:0]    seed_red,
  input  logic [nsvp_pkg::COLOR_W-1:0]    seed_green,
  input  logic [nsvp_pkg::COLOR_W-1:0]    seed_blue,
  input  logic [nsvp_pkg::COORD_W-1:0]    pixel_x,
  input  logic [nsvp_pkg::COORD_W-1:0]    pixel_y,
  output logic                            op_valid,
  input  logic                            op_ready,
  output nsvp_pkg::op_t                   op
);

  localparam int QD = nsvp_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int FW = $clog2(QD + 1);

  nsvp_pkg::op_t        qmem [QD];
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [FW-1:0]        fill;
  nsvp_pkg::op_t        op_in;
  logic                 keep;
  logic                 enq;
  logic                 deq;

  // Classify: loads aimed past the table are dropped here.
  always_comb begin
    op_in.cmd   = nsvp_pkg::cmd_t'(command);
    op_in.idx   = seed_index;
    op_in.red   = seed_red;
    op_in.green = seed_green;
    op_in.blue  = seed_blue;
    if (op_in.cmd == nsvp_pkg::CMD_QUERY) begin
      op_in.x = pixel_x;
      op_in.y = pixel_y;
    end else begin
      op_in.x = seed_x;
      op_in.y = seed_y;
    end
    keep = (op_in.cmd == nsvp_pkg::CMD_QUERY) || (32'(seed_index) < MAX_SEEDS);
  end

  assign full     = (fill == FW'(QD));
  assign op_valid = (fill != '0);
  assign op       = qmem[rd_ptr];
  assign enq      = push && !full && keep;
  assign deq      = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (enq) begin
      qmem[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      case ({enq, deq})
        2'b10:   fill <= FW'(fill + 1'b1);
        2'b01:   fill <= FW'(fill - 1'b1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> hdl/nsvp_back.sv
module nsvp_back #(
  parameter int MAX_SEEDS  = 16,
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [nsvp_pkg::COUNT_W-1:0]  seed_count,
  input  logic                          op_valid,
  output logic                          op_ready,
  input  nsvp_pkg::op_t                 op,
  input  logic                          res_pop,
  output nsvp_pkg::result_t             res,
  output nsvp_pkg::back_status_t        status
);

  localparam int AW    = $clog2(MAX_SEEDS);
  localparam int CNT_W = $clog2(MAX_SEEDS + 1);
  localparam int CW    = COORD_BITS;
  localparam int COL_W = 3 * nsvp_pkg::COLOR_W;
  localparam int EW    = 2 * CW + COL_W;
  localparam int SQ_W  = 2 * CW;
  localparam int DW    = SQ_W + 1;
  localparam int IW    = nsvp_pkg::IDX_W;
  localparam int CL_W  = nsvp_pkg::COLOR_W;

  nsvp_pkg::back_state_t state;
  nsvp_pkg::back_state_t state_next;

  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] iss_cnt;
  logic [CW-1:0]    px_q;
  logic [CW-1:0]    py_q;
  logic             none_q;

  logic             start;
  logic             issue;
  logic             finish;
  logic             ram_we;
  logic [AW-1:0]    waddr;
  logic [EW-1:0]    wdata;
  logic [EW-1:0]    rdata;

  logic             v1, last1;
  logic [AW-1:0]    idx1;
  logic             v2, last2;
  logic [AW-1:0]    idx2;
  logic [CW-1:0]    dx2, dy2;
  logic [COL_W-1:0] col2;
  logic             v3, last3;
  logic [AW-1:0]    idx3;
  logic [SQ_W-1:0]  sqx3, sqy3;
  logic [COL_W-1:0] col3;

  logic [CW-1:0]    sx, sy;
  logic [DW-1:0]    dist3;
  logic [DW-1:0]    best_dist;
  logic [AW-1:0]    best_idx;
  logic [COL_W-1:0] best_col;
  logic             res_valid;

  // Counts past the table size saturate.
  always_comb begin
    if (32'(seed_count) > MAX_SEEDS) begin
      count_eff = CNT_W'(MAX_SEEDS);
    end else begin
      count_eff = CNT_W'(seed_count);
    end
  end

  // FSM outputs
  always_comb begin
    op_ready = (state == nsvp_pkg::ST_IDLE);
    start    = op_valid && op_ready && (op.cmd == nsvp_pkg::CMD_QUERY);
    ram_we   = op_valid && op_ready && (op.cmd == nsvp_pkg::CMD_LOAD);
    issue    = (state == nsvp_pkg::ST_SCAN) && (iss_cnt < count_q);
    finish   = (state == nsvp_pkg::ST_DONE) && (!res_valid || res_pop);
  end

  // FSM next state
  always_comb begin
    state_next = state;
    case (state)
      nsvp_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (count_eff == '0) ? nsvp_pkg::ST_DONE : nsvp_pkg::ST_SCAN;
        end
      end
      nsvp_pkg::ST_SCAN: begin
        if (v3 && last3) begin
          state_next = nsvp_pkg::ST_DONE;
        end
      end
      nsvp_pkg::ST_DONE: begin
        if (finish) begin
          state_next = nsvp_pkg::ST_IDLE;
        end
      end
      default: state_next = nsvp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nsvp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Seed table: {x, y, red, green, blue}
  assign waddr = AW'(op.idx);
  assign wdata = {CW'(op.x), CW'(op.y), op.red, op.green, op.blue};

  nsvp_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_SEEDS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(iss_cnt[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (start) begin
      count_q <= count_eff;
      none_q  <= (count_eff == '0);
      px_q    <= CW'(op.x);
      py_q    <= CW'(op.y);
      iss_cnt <= '0;
    end else if (issue) begin
      iss_cnt <= CNT_W'(iss_cnt + 1'b1);
    end
  end

  // Scan pipeline: read, abs diff, square, accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign sx = rdata[EW-1 -: CW];
  assign sy = rdata[EW-CW-1 -: CW];

  always_ff @(posedge clk) begin
    last1 <= (CNT_W'(iss_cnt + 1'b1) == count_q);
    idx1  <= iss_cnt[AW-1:0];
    last2 <= last1;
    idx2  <= idx1;
    dx2   <= (sx >= px_q) ? CW'(sx - px_q) : CW'(px_q - sx);
    dy2   <= (sy >= py_q) ? CW'(sy - py_q) : CW'(py_q - sy);
    col2  <= rdata[COL_W-1:0];
    last3 <= last2;
    idx3  <= idx2;
    sqx3  <= SQ_W'(dx2) * SQ_W'(dx2);
    sqy3  <= SQ_W'(dy2) * SQ_W'(dy2);
    col3  <= col2;
  end

  assign dist3 = DW'(sqx3) + DW'(sqy3);

  // Strict less-than keeps the lowest index on ties.
  always_ff @(posedge clk) begin
    if (v3 && ((idx3 == '0) || (dist3 < best_dist))) begin
      best_dist <= dist3;
      best_idx  <= idx3;
      best_col  <= col3;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (none_q) begin
        res.red     <= '0;
        res.green   <= '0;
        res.blue    <= '0;
        res.idx     <= '0;
        res.no_seed <= 1'b1;
      end else begin
        res.red     <= best_col[3*CL_W-1 -: CL_W];
        res.green   <= best_col[2*CL_W-1 -: CL_W];
        res.blue    <= best_col[CL_W-1:0];
        res.idx     <= IW'(best_idx);
        res.no_seed <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  assign status.state        = state;
  assign status.result_valid = res_valid;

endmodule

>>> verif/nearest_seed_voronoi_pixel_top_tb.sv
// Testbench for the nearest-seed Voronoi pixel colorer.
module nearest_seed_voronoi_pixel_top_tb;
  import nsvp_pkg::*;

  // Loads give no result, so after the last result pops we still let the
  // block settle before touching seed_count.
  localparam int SETTLE_CYCLES = 48;
  localparam int TABLE_DEPTH   = 16;
  // Watchdog limit for the whole run.
  localparam int LIMIT_CYCLES  = 400000;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } seed_rec_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                seed_count_we;
  logic [COUNT_W-1:0]  seed_count;
  logic                push;
  logic                full;
  logic                command;
  logic [IDX_W-1:0]    seed_index;
  logic [COORD_W-1:0]  seed_x;
  logic [COORD_W-1:0]  seed_y;
  logic [COLOR_W-1:0]  seed_red;
  logic [COLOR_W-1:0]  seed_green;
  logic [COLOR_W-1:0]  seed_blue;
  logic [COORD_W-1:0]  pixel_x;
  logic [COORD_W-1:0]  pixel_y;
  logic                empty;
  logic                pop;
  logic [COLOR_W-1:0]  out_red;
  logic [COLOR_W-1:0]  out_green;
  logic [COLOR_W-1:0]  out_blue;
  logic [IDX_W-1:0]    nearest_index;
  logic                no_seed;

  // Our own copy of the seed table and of seed_count.
  seed_rec_t           seed_map [TABLE_DEPTH];
  int                  active_seeds;
  // Colors we expect back, oldest first.
  result_t             color_expect_q [$];

  int                  error_count;
  bit                  sender_gaps_on;
  bit                  pop_stalls_on;
  int                  hold_cycles;
  logic [COORD_W-1:0]  cluster_base;

  nearest_seed_voronoi_pixel_top DUT (
    .clk           (clk),
    .rst           (rst),
    .seed_count_we (seed_count_we),
    .seed_count    (seed_count),
    .push          (push),
    .full          (full),
    .command       (command),
    .seed_index    (seed_index),
    .seed_x        (seed_x),
    .seed_y        (seed_y),
    .seed_red      (seed_red),
    .seed_green    (seed_green),
    .seed_blue     (seed_blue),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .empty         (empty),
    .pop           (pop),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .nearest_index (nearest_index),
    .no_seed       (no_seed)
  );

  always #6 clk = ~clk;

  // Brute-force scan over the active entries. Strict less-than keeps the
  // lowest index on a tie. A count above the table depth saturates.
  function automatic result_t nearest_seed(input logic [COORD_W-1:0] px,
                                           input logic [COORD_W-1:0] py);
    result_t res;
    int      lim;
    int      dx;
    int      dy;
    int      sq_dist;
    int      best_dist;
    int      best;
    res = '0;
    best = 0;
    best_dist = 0;
    lim = (active_seeds > TABLE_DEPTH) ? TABLE_DEPTH : active_seeds;
    if (lim == 0) begin
      res.no_seed = 1'b1;
      return res;
    end
    for (int i = 0; i < lim; i++) begin
      dx = int'(seed_map[i].x) - int'(px);
      dy = int'(seed_map[i].y) - int'(py);
      sq_dist = dx * dx + dy * dy;
      if (i == 0 || sq_dist < best_dist) begin
        best_dist = sq_dist;
        best = i;
      end
    end
    res.red   = seed_map[best].red;
    res.green = seed_map[best].green;
    res.blue  = seed_map[best].blue;
    res.idx   = IDX_W'(best);
    return res;
  endfunction

  // Corners, a small cluster (to make ties and near-ties likely) or anywhere.
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return COORD_W'(cluster_base + $urandom_range(0, 7));
      default: return COORD_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // Offer one item and hold it until the block takes it; update the
  // predictor at the accepting edge. push stays high for a following item.
  task automatic push_item(input cmd_t c, input logic [IDX_W-1:0] idx,
                           input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                           input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                           input logic [COLOR_W-1:0] b,
                           input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
    if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    push       <= 1'b1;
    command    <= c;
    seed_index <= idx;
    seed_x     <= sx;
    seed_y     <= sy;
    seed_red   <= r;
    seed_green <= g;
    seed_blue  <= b;
    pixel_x    <= px;
    pixel_y    <= py;
    do @(posedge clk); while (full);
    if (c == CMD_LOAD) begin
      seed_map[idx] = '{x: sx, y: sy, red: r, green: g, blue: b};
    end else begin
      color_expect_q.push_back(nearest_seed(px, py));
    end
  endtask

  // Load with junk on the pixel fields, query with junk on the seed fields,
  // so the unused fields toggle too.
  task automatic load_seed(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] sx,
                           input logic [COORD_W-1:0] sy, input logic [COLOR_W-1:0] r,
                           input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
    push_item(CMD_LOAD, idx, sx, sy, r, g, b,
              COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic query_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
    push_item(CMD_QUERY, IDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom), px, py);
  endtask

  // Stop offering, wait for every expected result, then let trailing loads
  // finish in the back end.
  task automatic wait_idle();
    push <= 1'b0;
    while (color_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed_count(input logic [COUNT_W-1:0] value);
    seed_count_we <= 1'b1;
    seed_count    <= value;
    @(posedge clk);
    seed_count_we <= 1'b0;
    active_seeds = value;
  endtask

  // Straight after reset seed_count is 0: every query must say no_seed.
  task automatic test_empty_table();
    query_pixel('0, '0);
    query_pixel('1, '1);
    wait_idle();
    write_seed_count('0);
    query_pixel(12'h5A5, 12'hA5A);
    wait_idle();
  endtask

  // Fill the whole table so that no query can ever touch an unwritten entry.
  // Entry 0 sits at the origin in black, entry 15 at the far corner in white.
  task automatic test_fill_table();
    load_seed(4'd0, '0, '0, '0, '0, '0);
    for (int i = 1; i < TABLE_DEPTH - 1; i++)
      load_seed(IDX_W'(i), COORD_W'($urandom), COORD_W'($urandom),
                COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
    load_seed(4'd15, '1, '1, '1, '1, '1);
    wait_idle();
  endtask

  // Ties, single seed, and a saturated count.
  task automatic test_ties_and_counts();
    write_seed_count(5'd16);
    // two seeds on the same spot: the lower index has to win
    load_seed(4'd4, 12'd100, 12'd100, 8'h11, 8'h22, 8'h33);
    load_seed(4'd9, 12'd100, 12'd100, 8'hCC, 8'hDD, 8'hEE);
    query_pixel(12'd100, 12'd100);
    // equal distance from two different positions
    load_seed(4'd2, 12'd200, 12'd300, 8'h01, 8'h02, 8'h03);
    load_seed(4'd7, 12'd204, 12'd300, 8'h0A, 8'h0B, 8'h0C);
    query_pixel(12'd202, 12'd300);
    // far corners, largest distances
    query_pixel('1, '0);
    query_pixel('0, '1);
    wait_idle();
    write_seed_count(5'd1);
    query_pixel(12'd2048, 12'd2048);
    wait_idle();
    // above the table depth the count acts as sixteen
    write_seed_count('1);
    query_pixel('1, '1);
    query_pixel(12'd100, 12'd100);
    wait_idle();
  endtask

  // Mostly short runs of loads followed by queries on fresh positions.
  task automatic run_mixed(input int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      cluster_base = COORD_W'($urandom);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        load_seed(IDX_W'($urandom), pick_coord(), pick_coord(),
                  COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
        sent++;
      end
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        query_pixel(pick_coord(), pick_coord());
        sent++;
      end
    end
  endtask

  // Walk through several seed_count settings, extremes included.
  task automatic test_random_counts();
    logic [COUNT_W-1:0] counts [8];
    counts = '{5'd16, 5'd1, 5'd31, 5'd17, 5'd0, COUNT_W'($urandom_range(2, 15)),
               COUNT_W'($urandom_range(2, 15)), 5'd16};
    foreach (counts[k]) begin
      write_seed_count(counts[k]);
      run_mixed(140);
      wait_idle();
    end
  endtask

  // Receiver holds off for a long stretch while queries keep coming, so the
  // result side and the command queue fill and full must rise.
  task automatic test_backpressure();
    sender_gaps_on = 1'b0;
    hold_cycles = 300;
    for (int i = 0; i < 30; i++)
      query_pixel(pick_coord(), pick_coord());
    wait_idle();
    sender_gaps_on = 1'b1;
  endtask

  // Last stretch: both sides flat out.
  task automatic test_full_rate();
    sender_gaps_on = 1'b0;
    pop_stalls_on  = 1'b0;
    write_seed_count(5'd16);
    run_mixed(150);
    wait_idle();
  endtask

  // Pop side: random bursts of popping and stalling, plus the long hold
  // that a test can request through hold_cycles.
  initial begin : result_drain
    int n;
    pop <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (pop_stalls_on && $urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Compare every popped result with the oldest expectation. Values read
  // here are the ones from before the edge.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && pop && !empty) begin
      if (color_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0h/%0h/%0h idx %0d no_seed %0b",
                 $time, out_red, out_green, out_blue, nearest_index, no_seed);
        error_count++;
      end else begin
        want = color_expect_q.pop_front();
        if (out_red !== want.red) begin
          $display("%0t: out_red expected %0h got %0h", $time, want.red, out_red);
          error_count++;
        end
        if (out_green !== want.green) begin
          $display("%0t: out_green expected %0h got %0h", $time, want.green, out_green);
          error_count++;
        end
        if (out_blue !== want.blue) begin
          $display("%0t: out_blue expected %0h got %0h", $time, want.blue, out_blue);
          error_count++;
        end
        if (nearest_index !== want.idx) begin
          $display("%0t: nearest_index expected %0d got %0d", $time, want.idx, nearest_index);
          error_count++;
        end
        if (no_seed !== want.no_seed) begin
          $display("%0t: no_seed expected %0b got %0b", $time, want.no_seed, no_seed);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 12);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main_seq
    error_count    = 0;
    hold_cycles    = 0;
    active_seeds   = 0;
    sender_gaps_on = 1'b1;
    pop_stalls_on  = 1'b1;
    cluster_base   = '0;
    foreach (seed_map[i]) seed_map[i] = '{default: '0};
    rst           <= 1'b1;
    seed_count_we <= 1'b0;
    seed_count    <= '0;
    push          <= 1'b0;
    command       <= CMD_LOAD;
    seed_index    <= '0;
    seed_x        <= '0;
    seed_y        <= '0;
    seed_red      <= '0;
    seed_green    <= '0;
    seed_blue     <= '0;
    pixel_x       <= '0;
    pixel_y       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_fill_table();
    test_ties_and_counts();
    test_random_counts();
    test_backpressure();
    test_full_rate();

    wait_idle();
    if (error_count == 0 && color_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> nearest_seed_voronoi_pixel_top.f
hdl/nsvp_pkg.sv
hdl/nsvp_ram.sv
hdl/nsvp_front.sv
hdl/nsvp_back.sv
hdl/nearest_seed_voronoi_pixel_top.sv
verif/nearest_seed_voronoi_pixel_top_tb.sv
